>>> hw/rtl/pda_pkg.sv
// Package for the point direction angle unit: widths, turn constants,
// the CORDIC arctangent table and the types shared between the modules.
// Depends on nothing; every other file refers to it by scoped names.
package pda_pkg;

    // Field and datapath widths.
    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int ITERATIONS  = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int XY_WIDTH    = 64;
    localparam int PRESHIFT    = 60 - COORD_WIDTH;
    localparam int TURN_BITS   = 32;
    localparam int STEP_IDX_W  = 5;

    // Fractions of a full turn in units of 2^-32 of a turn.
    localparam logic [TURN_BITS-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [TURN_BITS-1:0] HALF_TURN    = 32'h8000_0000;

    // Rounding of the turn accumulator down to the output angle width.
    localparam int ROUND_SHIFT = TURN_BITS - ANGLE_WIDTH;
    localparam logic [TURN_BITS:0] ROUND_BIAS = (33'd1 << ROUND_SHIFT) >> 1;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // Cycles from the accepting edge to the edge that takes the result: front
    // register, queue, entry scaling register, one register per iteration,
    // unfolding register and output register.
    localparam int LATENCY = ITERATIONS + 5;

    // Octant folding decisions that the back needs to unfold the angle.
    typedef struct packed {
        logic swapped;
        logic neg_x;
        logic neg_y;
        logic coincident;
    } t_flags;

    // One classified point pair as it travels through the queue.
    typedef struct packed {
        logic [DIFF_WIDTH-1:0] mag_major;
        logic [DIFF_WIDTH-1:0] mag_minor;
        t_flags                flags;
    } t_item;

    // Queue fill status as seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Rounded atan(2^-idx) as a fraction of a full turn, 2^32 per turn.
    function automatic logic [TURN_BITS-1:0] atan_step(input logic [STEP_IDX_W-1:0] idx);
        logic [TURN_BITS-1:0] val;
        unique case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            5'd24:   val = 32'h00000029;
            5'd25:   val = 32'h00000014;
            5'd26:   val = 32'h0000000A;
            5'd27:   val = 32'h00000005;
            5'd28:   val = 32'h00000003;
            5'd29:   val = 32'h00000001;
            5'd30:   val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

>>> hw/rtl/pda_front.sv
// Front of the point direction angle unit: accepts a point pair, forms the
// difference vector and folds it into the first octant. Uses pda_pkg.
module pda_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [pda_pkg::COORD_WIDTH-1:0] i_ref_x,
    input  logic signed [pda_pkg::COORD_WIDTH-1:0] i_ref_y,
    input  logic signed [pda_pkg::COORD_WIDTH-1:0] i_target_x,
    input  logic signed [pda_pkg::COORD_WIDTH-1:0] i_target_y,
    input  pda_pkg::t_queue_status               i_q_status,
    output logic                                 o_busy,
    output logic                                 o_push,
    output pda_pkg::t_item                       o_item
);

    logic                                      r_valid;
    logic                                      n_valid;
    pda_pkg::t_item                            r_item;
    pda_pkg::t_item                            n_item;
    logic                                      accept;
    logic signed [pda_pkg::DIFF_WIDTH-1:0]     dx;
    logic signed [pda_pkg::DIFF_WIDTH-1:0]     dy;
    logic [pda_pkg::DIFF_WIDTH-1:0]            abs_x;
    logic [pda_pkg::DIFF_WIDTH-1:0]            abs_y;

    // The held item leaves for the queue whenever the queue has room.
    assign o_push = r_valid && !i_q_status.full;
    assign o_busy = r_valid && i_q_status.full;
    assign accept = i_start && !o_busy;
    assign o_item = r_item;

    // Difference vector, magnitudes and octant folding.
    always_comb begin
        dx = pda_pkg::DIFF_WIDTH'(i_target_x) - pda_pkg::DIFF_WIDTH'(i_ref_x);
        dy = pda_pkg::DIFF_WIDTH'(i_target_y) - pda_pkg::DIFF_WIDTH'(i_ref_y);
        abs_x = dx[pda_pkg::DIFF_WIDTH-1] ? -dx : dx;
        abs_y = dy[pda_pkg::DIFF_WIDTH-1] ? -dy : dy;
        n_item.flags.swapped    = abs_y > abs_x;
        n_item.flags.neg_x      = dx[pda_pkg::DIFF_WIDTH-1];
        n_item.flags.neg_y      = dy[pda_pkg::DIFF_WIDTH-1];
        n_item.flags.coincident = (dx == '0) && (dy == '0);
        n_item.mag_major = n_item.flags.swapped ? abs_y : abs_x;
        n_item.mag_minor = n_item.flags.swapped ? abs_x : abs_y;
    end

    // Holding register occupancy.
    always_comb begin
        n_valid = accept || (r_valid && !o_push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload of the held transaction.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

>>> hw/rtl/pda_queue.sv
// Short queue that decouples the front from the CORDIC back.
// Uses pda_pkg for the item type and the queue depth.
module pda_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  pda_pkg::t_item         i_item,
    input  logic                   i_pop,
    output pda_pkg::t_queue_status o_status,
    output pda_pkg::t_item         o_item
);

    pda_pkg::t_item                    r_mem [pda_pkg::QUEUE_DEPTH];
    logic [pda_pkg::QPTR_WIDTH-1:0]    r_wr_ptr;
    logic [pda_pkg::QPTR_WIDTH-1:0]    r_rd_ptr;
    logic [pda_pkg::QCNT_WIDTH-1:0]    r_count;
    logic [pda_pkg::QPTR_WIDTH-1:0]    n_wr_ptr;
    logic [pda_pkg::QPTR_WIDTH-1:0]    n_rd_ptr;
    logic [pda_pkg::QCNT_WIDTH-1:0]    n_count;

    assign o_status.full  = r_count == pda_pkg::QCNT_WIDTH'(pda_pkg::QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_item         = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == pda_pkg::QPTR_WIDTH'(pda_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == pda_pkg::QPTR_WIDTH'(pda_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> hw/rtl/pda_back.sv
// Back of the point direction angle unit: pipelined CORDIC vectoring, octant
// unfolding and rounding to the output angle. Uses pda_pkg.
module pda_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  pda_pkg::t_item                    i_item,
    output logic                              o_done,
    output logic [pda_pkg::ANGLE_WIDTH-1:0]   o_angle,
    output logic                              o_coincident
);

    localparam int NS = pda_pkg::ITERATIONS;
    localparam int XW = pda_pkg::XY_WIDTH;
    localparam int TW = pda_pkg::TURN_BITS;

    // Pipeline registers, one set per iteration boundary.
    logic signed [XW-1:0]  r_x    [NS+1];
    logic signed [XW-1:0]  r_y    [NS+1];
    logic [TW-1:0]         r_z    [NS+1];
    pda_pkg::t_flags       r_flag [NS+1];
    logic                  r_vld  [NS+1];
    logic signed [XW-1:0]  n_x    [NS+1];
    logic signed [XW-1:0]  n_y    [NS+1];
    logic [TW-1:0]         n_z    [NS+1];

    logic                  r_u_vld;
    logic [TW-1:0]         r_u_t;
    logic                  r_u_coinc;
    logic [TW-1:0]         n_u_t;
    logic [TW-1:0]         off_swap;
    logic [TW-1:0]         off_x;
    logic [TW-1:0]         off_y;
    logic                  flip;

    logic                  r_done;
    logic [pda_pkg::ANGLE_WIDTH-1:0] r_angle;
    logic                  r_coinc;
    logic [TW:0]           n_sum;

    // Stage 0: scale the folded magnitudes into the working format.
    always_comb begin
        n_x[0] = $signed(XW'(i_item.mag_major) << pda_pkg::PRESHIFT);
        n_y[0] = $signed(XW'(i_item.mag_minor) << pda_pkg::PRESHIFT);
        n_z[0] = '0;
    end

    // One CORDIC rotation per stage, always driving y toward zero.
    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic                 y_pos;
        logic                 y_neg;
        logic [TW-1:0]        step;

        assign xs    = r_x[s] >>> s;
        assign ys    = r_y[s] >>> s;
        assign y_neg = r_y[s][XW-1];
        assign y_pos = !r_y[s][XW-1] && (r_y[s] != '0);
        assign step  = pda_pkg::atan_step(pda_pkg::STEP_IDX_W'(s));

        always_comb begin
            n_x[s+1] = r_x[s];
            n_y[s+1] = r_y[s];
            n_z[s+1] = r_z[s];
            if (y_pos) begin
                n_x[s+1] = r_x[s] + ys;
                n_y[s+1] = r_y[s] - xs;
                n_z[s+1] = r_z[s] + step;
            end else if (y_neg) begin
                n_x[s+1] = r_x[s] - ys;
                n_y[s+1] = r_y[s] + xs;
                n_z[s+1] = r_z[s] - step;
            end
        end
    end

    // Valid chain of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Datapath of the pipeline.
    always_ff @(posedge i_clk) begin
        r_flag[0] <= i_item.flags;
        for (int k = 0; k <= NS; k++) begin
            r_x[k] <= n_x[k];
            r_y[k] <= n_y[k];
            r_z[k] <= n_z[k];
        end
        for (int k = 1; k <= NS; k++) begin
            r_flag[k] <= r_flag[k-1];
        end
    end

    // Unfolding reduces to one add: the angle becomes offset plus or minus z.
    always_comb begin
        off_swap = r_flag[NS].swapped ? pda_pkg::QUARTER_TURN : '0;
        off_x    = r_flag[NS].neg_x ? pda_pkg::HALF_TURN - off_swap : off_swap;
        off_y    = r_flag[NS].neg_y ? '0 - off_x : off_x;
        flip     = r_flag[NS].swapped ^ r_flag[NS].neg_x ^ r_flag[NS].neg_y;
        n_u_t    = flip ? off_y - r_z[NS] : off_y + r_z[NS];
    end

    // Round half up to the output width; a full turn wraps to zero.
    always_comb begin
        n_sum = {1'b0, r_u_t} + pda_pkg::ROUND_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_u_vld <= r_vld[NS];
            r_done  <= r_u_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u_t     <= n_u_t;
        r_u_coinc <= r_flag[NS].coincident;
        r_angle   <= n_sum[pda_pkg::ROUND_SHIFT +: pda_pkg::ANGLE_WIDTH];
        r_coinc   <= r_u_coinc;
    end

    assign o_done       = r_done;
    assign o_angle      = r_angle;
    assign o_coincident = r_coinc;

endmodule

>>> hw/rtl/point_direction_angle_unit.sv
// Top level of the point direction angle unit: front, queue and CORDIC back.
// Uses pda_pkg, pda_front, pda_queue and pda_back.
//
// The unit takes a reference and a target point per transaction (start high
// while busy is low) and returns the direction from reference to target as a
// fraction of a full turn, 2^ANGLE_WIDTH per turn, counterclockwise from +x.
// One transaction can be accepted every clock cycle. Each result appears on
// o_angle and o_coincident with o_done high for exactly one cycle. Between
// the accepting edge and the edge that takes the result lie the front
// register, the queue, the scaling register at the pipeline entry, the
// one-stage-per-iteration CORDIC pipeline, the unfolding stage and the
// output register. The receiver cannot hold results off, and the back takes
// an item every cycle, so the queue never fills and busy stays low.
// Coincident points give angle zero with o_coincident set.
module point_direction_angle_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [pda_pkg::COORD_WIDTH-1:0] i_ref_x,
    input  logic signed [pda_pkg::COORD_WIDTH-1:0] i_ref_y,
    input  logic signed [pda_pkg::COORD_WIDTH-1:0] i_target_x,
    input  logic signed [pda_pkg::COORD_WIDTH-1:0] i_target_y,
    output logic                                   o_done,
    output logic [pda_pkg::ANGLE_WIDTH-1:0]        o_angle,
    output logic                                   o_coincident
);

    pda_pkg::t_queue_status q_status;
    pda_pkg::t_item         front_item;
    pda_pkg::t_item         back_item;
    logic                   q_push;
    logic                   q_pop;

    // The back takes one item every cycle, so the queue drains freely.
    assign q_pop = !q_status.empty;

    // Classification of incoming transactions.
    pda_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_ref_x    (i_ref_x),
        .i_ref_y    (i_ref_y),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .i_q_status (q_status),
        .o_busy     (busy),
        .o_push     (q_push),
        .o_item     (front_item)
    );

    // Decoupling queue.
    pda_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (front_item),
        .i_pop    (q_pop),
        .o_status (q_status),
        .o_item   (back_item)
    );

    // CORDIC pipeline and result formatting.
    pda_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_pop),
        .i_item       (back_item),
        .o_done       (o_done),
        .o_angle      (o_angle),
        .o_coincident (o_coincident)
    );

endmodule

>>> hw/rtl/pda_checker.sv
// Port-level checker for the point direction angle unit, with its bind.
// Uses pda_pkg for widths and the fixed result latency.
module pda_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic signed [pda_pkg::COORD_WIDTH-1:0] i_ref_x,
    input logic signed [pda_pkg::COORD_WIDTH-1:0] i_ref_y,
    input logic signed [pda_pkg::COORD_WIDTH-1:0] i_target_x,
    input logic signed [pda_pkg::COORD_WIDTH-1:0] i_target_y,
    input logic                                   o_done,
    input logic [pda_pkg::ANGLE_WIDTH-1:0]        o_angle,
    input logic                                   o_coincident
);

    logic accept;
    logic same_point;

    assign accept     = start && !busy;
    assign same_point = (i_ref_x == i_target_x) && (i_ref_y == i_target_y);

    // The back never stalls, so the front never has to refuse a transaction.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised although the back drains every cycle");

    // Every accepted transaction yields its result after the fixed latency.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(pda_pkg::LATENCY)
            (o_done && (o_coincident == $past(same_point, pda_pkg::LATENCY))))
        else $error("missing result or wrong coincidence flag");

    // No result without a transaction accepted the fixed latency earlier.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, pda_pkg::LATENCY))
        else $error("result strobe without a matching transaction");

    // Coincident points always report angle zero.
    a_coincident_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_coincident) |-> (o_angle == '0))
        else $error("coincident result with nonzero angle");

endmodule

bind point_direction_angle_unit pda_checker u_pda_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_ref_x      (i_ref_x),
    .i_ref_y      (i_ref_y),
    .i_target_x   (i_target_x),
    .i_target_y   (i_target_y),
    .o_done       (o_done),
    .o_angle      (o_angle),
    .o_coincident (o_coincident)
);

>>> sim/tb_point_direction_angle_unit.sv
// Testbench for the point direction angle unit: a local CORDIC predictor of
// the direction angle checks every result in order. Depends on pda_pkg and
// point_direction_angle_unit only.
module tb_point_direction_angle_unit;

    localparam int CW           = pda_pkg::COORD_WIDTH;
    localparam int AW           = pda_pkg::ANGLE_WIDTH;
    localparam int STEPS        = pda_pkg::ITERATIONS;
    localparam int MAG_SHIFT    = 60 - CW;
    localparam int ANGLE_SHIFT  = 32 - AW;
    localparam int PIPE_CYCLES  = pda_pkg::ITERATIONS + 4;
    localparam int STALL_LIMIT  = 1000;
    localparam int REPORT_LIMIT = 10;

    localparam logic [31:0] QUARTER = 32'h4000_0000;
    localparam logic [31:0] HALF    = 32'h8000_0000;

    // Rounded atan(2^-k) in units of 2^-32 of a full turn.
    localparam logic [31:0] ATAN_TURN [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic [AW-1:0] angle;
        logic          coincident;
    } t_direction;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    t_coord        i_ref_x;
    t_coord        i_ref_y;
    t_coord        i_target_x;
    t_coord        i_target_y;
    logic          o_done;
    logic [AW-1:0] o_angle;
    logic          o_coincident;

    t_direction pending_directions[$];
    int         mismatch_count;
    int         stall_cycles;

    point_direction_angle_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_ref_x      (i_ref_x),
        .i_ref_y      (i_ref_y),
        .i_target_x   (i_target_x),
        .i_target_y   (i_target_y),
        .o_done       (o_done),
        .o_angle      (o_angle),
        .o_coincident (o_coincident)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Direction of the vector from the reference to the target point: fold
    // into the first octant, run the CORDIC vectoring steps, then unfold.
    function automatic t_direction predict_direction(input t_coord rx, input t_coord ry,
                                                     input t_coord tx, input t_coord ty);
        longint      dx;
        longint      dy;
        longint      major;
        longint      minor;
        longint      held;
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        longint      z;
        logic        swapped;
        logic [31:0] turn;
        logic [32:0] rounded;
        t_direction  dir;
        int          k;
        dx = longint'(tx) - longint'(rx);
        dy = longint'(ty) - longint'(ry);
        if (dx == 0 && dy == 0) begin
            dir.angle      = '0;
            dir.coincident = 1'b1;
            return dir;
        end
        major   = (dx < 0) ? -dx : dx;
        minor   = (dy < 0) ? -dy : dy;
        swapped = minor > major;
        if (swapped) begin
            held  = major;
            major = minor;
            minor = held;
        end
        x = major <<< MAG_SHIFT;
        y = minor <<< MAG_SHIFT;
        z = 0;
        for (k = 0; k < STEPS && k < 32; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TURN[k]);
            end else if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TURN[k]);
            end
        end
        turn = z[31:0];
        if (swapped) begin
            turn = QUARTER - turn;
        end
        if (dx < 0) begin
            turn = HALF - turn;
        end
        if (dy < 0) begin
            turn = 32'd0 - turn;
        end
        // Round half up to the output width; a full turn wraps to zero.
        rounded        = {1'b0, turn} + ((33'd1 << ANGLE_SHIFT) >> 1);
        dir.angle      = AW'(rounded >> ANGLE_SHIFT);
        dir.coincident = 1'b0;
        return dir;
    endfunction

    // Count a failure and report the first few of them.
    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("Mismatch at %0t: %s", $time, what);
        end
    endtask

    // Compare every result with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_direction want;
        if (o_done === 1'b1) begin
            if (pending_directions.size() == 0) begin
                note_mismatch($sformatf("result with none outstanding, angle %0d",
                                        o_angle));
            end else begin
                want = pending_directions.pop_front();
                if (o_angle !== want.angle) begin
                    note_mismatch($sformatf("angle expected %0d, got %0d",
                                            want.angle, o_angle));
                end
                if (o_coincident !== want.coincident) begin
                    note_mismatch($sformatf("coincident expected %0b, got %0b",
                                            want.coincident, o_coincident));
                end
            end
        end
    end

    // Watchdog: end the run when neither side moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one point pair and wait until the unit takes the transaction.
    task automatic send_points(input t_coord rx, input t_coord ry,
                               input t_coord tx, input t_coord ty);
        t_direction want;
        want = predict_direction(rx, ry, tx, ty);
        i_ref_x    <= rx;
        i_ref_y    <= ry;
        i_target_x <= tx;
        i_target_y <= ty;
        start      <= 1'b1;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pending_directions.push_back(want);
    endtask

    // Offer a target given as an offset from the reference point.
    task automatic send_offset(input int rx, input int ry, input int dx, input int dy);
        send_points(t_coord'(rx), t_coord'(ry), t_coord'(rx + dx), t_coord'(ry + dy));
    endtask

    // Sender gap, taken at random within the stretches that allow gaps.
    task automatic maybe_pause(input int idx);
        if (idx % 100 < 60 && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Field extremes, all four axis directions, diagonals, coincident points
    // and angles that round up to a full turn.
    task automatic test_special_cases();
        send_points(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_points(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        send_points(16'sd0, 16'sd0, 16'sd5, 16'sd0);
        send_points(16'sd0, 16'sd0, 16'sd0, 16'sd5);
        maybe_pause(0);
        send_points(16'sd0, 16'sd0, -16'sd5, 16'sd0);
        send_points(16'sd0, 16'sd0, 16'sd0, -16'sd5);
        send_points(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0);
        send_points(16'sd32767, 16'sd0, -16'sd32768, 16'sd0);
        send_points(16'sd0, -16'sd32768, 16'sd0, 16'sd32767);
        maybe_pause(1);
        send_points(16'sd0, 16'sd32767, 16'sd0, -16'sd32768);
        send_points(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_points(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
        send_points(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
        send_points(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
        send_points(16'sd0, 16'sd0, 16'sd1, 16'sd1);
        send_points(16'sd0, 16'sd0, -16'sd1, 16'sd1);
        maybe_pause(2);
        send_points(16'sd0, 16'sd0, -16'sd1, -16'sd1);
        send_points(16'sd0, 16'sd0, 16'sd1, -16'sd1);
        send_points(-16'sd32768, 16'sd0, 16'sd32767, -16'sd1);
        send_points(16'sd0, 16'sd0, 16'sd32767, -16'sd1);
        send_points(-16'sd32768, -16'sd32768, -16'sd32767, 16'sd32767);
        send_points(16'sd32767, 16'sd32767, 16'sd32766, -16'sd32768);
    endtask

    // Fully random coordinates.
    task automatic test_random_pairs(input int count);
        for (int n = 0; n < count; n++) begin
            send_points(t_coord'($urandom), t_coord'($urandom),
                        t_coord'($urandom), t_coord'($urandom));
            maybe_pause(n);
        end
    endtask

    // Targets close to the reference: small vectors hit every octant,
    // both axes and equal magnitudes often.
    task automatic test_short_vectors(input int count);
        for (int n = 0; n < count; n++) begin
            send_offset(int'($urandom_range(0, 65519)) - 32760,
                        int'($urandom_range(0, 65519)) - 32760,
                        int'($urandom_range(0, 16)) - 8,
                        int'($urandom_range(0, 16)) - 8);
            maybe_pause(n);
        end
    endtask

    // Vectors on or right next to the octant boundaries at random scale.
    task automatic test_octant_boundaries(input int count);
        int mag;
        int ax;
        int ay;
        for (int n = 0; n < count; n++) begin
            mag = $urandom_range(1, 16383);
            case ($urandom_range(0, 3))
                0: begin
                    ax = $urandom_range(0, 1) ? mag : 0;
                    ay = (ax == 0) ? mag : 0;
                end
                1: begin
                    ax = mag;
                    ay = mag;
                end
                2: begin
                    ax = mag;
                    ay = mag + 1;
                end
                default: begin
                    ax = mag + 1;
                    ay = mag;
                end
            endcase
            if ($urandom_range(0, 1)) begin
                ax = -ax;
            end
            if ($urandom_range(0, 1)) begin
                ay = -ay;
            end
            send_offset(int'($urandom_range(0, 32767)) - 16384,
                        int'($urandom_range(0, 32767)) - 16384, ax, ay);
            maybe_pause(n);
        end
    endtask

    // One transaction per cycle with no gaps at all.
    task automatic test_full_rate(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 1)) begin
                send_points(t_coord'($urandom), t_coord'($urandom),
                            t_coord'($urandom), t_coord'($urandom));
            end else begin
                send_offset(int'($urandom_range(0, 65519)) - 32760,
                            int'($urandom_range(0, 65519)) - 32760,
                            int'($urandom_range(0, 16)) - 8,
                            int'($urandom_range(0, 16)) - 8);
            end
        end
    endtask

    // Reset, run the tests in turn, drain and report.
    initial begin
        mismatch_count = 0;
        stall_cycles   = 0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_ref_x    <= '0;
        i_ref_y    <= '0;
        i_target_x <= '0;
        i_target_y <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        test_random_pairs(800);
        test_short_vectors(300);
        test_octant_boundaries(300);
        test_full_rate(330);
        start <= 1'b0;

        while (pending_directions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * PIPE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/pda_pkg.sv
hw/rtl/pda_front.sv
hw/rtl/pda_queue.sv
hw/rtl/pda_back.sv
hw/rtl/point_direction_angle_unit.sv
hw/rtl/pda_checker.sv
sim/tb_point_direction_angle_unit.sv
